// ===== rtl/bosc_pkg.sv =====
`timescale 1ns / 1ps

package bosc_pkg;

	localparam int CHAN_W = 8;
	localparam int WEIGHT_W = CHAN_W + 1;

	// full-scale alpha and unit weight in 1/256 steps
	localparam logic [CHAN_W-1:0]   ALPHA_MAX = 8'hff;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

	// number of quotient bits resolved in each divider stage
	localparam int DIV_BITS_PER_STAGE = 3;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} rgb_t;

	// after coverage: colors, coverage and output alpha
	typedef struct packed {
		rgb_t              src;
		rgb_t              tgt;
		logic              last;
		logic [CHAN_W-1:0] cov;
		logic [CHAN_W-1:0] oa;
	} alpha_st_t;

	// divider working word: partial remainder and quotient so far
	typedef struct packed {
		rgb_t                src;
		rgb_t                tgt;
		logic                last;
		logic [CHAN_W-1:0]   oa;
		logic [WEIGHT_W-1:0] rem;
		logic [WEIGHT_W-1:0] quo;
	} div_st_t;

	// composited pixel
	typedef struct packed {
		rgb_t              col;
		logic [CHAN_W-1:0] alpha;
		logic              last;
	} pixel_t;

endpackage

// ===== rtl/bosc_pair_if.sv =====
`timescale 1ns / 1ps

// source and target pixel pair, one word per handshake
interface bosc_pair_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_blue;
	logic [7:0] src_green;
	logic [7:0] src_red;
	logic [7:0] src_alpha;
	logic [7:0] tgt_blue;
	logic [7:0] tgt_green;
	logic [7:0] tgt_red;
	logic [7:0] tgt_alpha;
	logic       in_last;

	modport source(
		output valid, src_blue, src_green, src_red, src_alpha,
		output tgt_blue, tgt_green, tgt_red, tgt_alpha, in_last,
		input  ready
	);
	modport sink(
		input  valid, src_blue, src_green, src_red, src_alpha,
		input  tgt_blue, tgt_green, tgt_red, tgt_alpha, in_last,
		output ready
	);
endinterface

// ===== rtl/bosc_pixel_if.sv =====
`timescale 1ns / 1ps

// composited pixel, one word per handshake
interface bosc_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic [7:0] out_alpha;
	logic       out_last;

	modport source(
		output valid, out_blue, out_green, out_red, out_alpha, out_last,
		input  ready
	);
	modport sink(
		input  valid, out_blue, out_green, out_red, out_alpha, out_last,
		output ready
	);
endinterface

// ===== rtl/bgra_source_over_compositor.sv =====
`timescale 1ns / 1ps
// Source-over compositor for BGRA8 pixel pairs.
// Throughput: one pixel per cycle; six register stages (multiply, coverage,
// three divider stages at three quotient bits each, blend) with local stall.
// Reset: arst_n clears all stage valid bits at once; no other state.
module bgra_source_over_compositor (
	input  logic           clk,
	input  logic           arst_n,
	bosc_pair_if.sink      pixels,
	bosc_pixel_if.source   blended
);

	logic                valid_a;
	logic                ready_a;
	bosc_pkg::alpha_st_t data_a;
	logic                valid_d;
	logic                ready_d;
	bosc_pkg::div_st_t   data_d;
	bosc_pkg::pixel_t    px;
	bosc_pkg::rgb_t      src;
	bosc_pkg::rgb_t      tgt;

	assign src.blue  = pixels.src_blue;
	assign src.green = pixels.src_green;
	assign src.red   = pixels.src_red;
	assign tgt.blue  = pixels.tgt_blue;
	assign tgt.green = pixels.tgt_green;
	assign tgt.red   = pixels.tgt_red;

	bosc_alpha u_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixels.valid),
		.in_ready  (pixels.ready),
		.in_src    (src),
		.in_tgt    (tgt),
		.in_sa     (pixels.src_alpha),
		.in_ta     (pixels.tgt_alpha),
		.in_last   (pixels.in_last),
		.out_valid (valid_a),
		.out_ready (ready_a),
		.out_data  (data_a)
	);

	bosc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_a),
		.in_ready  (ready_a),
		.in_data   (data_a),
		.out_valid (valid_d),
		.out_ready (ready_d),
		.out_data  (data_d)
	);

	bosc_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_d),
		.in_ready  (ready_d),
		.in_data   (data_d),
		.out_valid (blended.valid),
		.out_ready (blended.ready),
		.out_data  (px)
	);

	assign blended.out_blue  = px.col.blue;
	assign blended.out_green = px.col.green;
	assign blended.out_red   = px.col.red;
	assign blended.out_alpha = px.alpha;
	assign blended.out_last  = px.last;

endmodule

// ===== rtl/bosc_alpha.sv =====
`timescale 1ns / 1ps

// Stages 1-2: target coverage tgt_a*(255-src_a)/255 and output alpha.
module bosc_alpha (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bosc_pkg::rgb_t     in_src,
	input  bosc_pkg::rgb_t     in_tgt,
	input  logic [7:0]         in_sa,
	input  logic [7:0]         in_ta,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_ready,
	output bosc_pkg::alpha_st_t out_data
);

	logic               valid_s1;
	bosc_pkg::rgb_t     src_s1;
	bosc_pkg::rgb_t     tgt_s1;
	logic [7:0]         sa_s1;
	logic               last_s1;
	logic [15:0]        prod_s1;

	logic               valid_s2;
	bosc_pkg::alpha_st_t st_s2;

	logic               adv_s1;
	logic               adv_s2;
	logic [15:0]        prod_c;
	logic [16:0]        div_sum;
	logic [7:0]         cov_c;
	logic [8:0]         oa_c;

	// a stage takes a new word when empty or when its word moves on
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// stage 1: coverage product
	assign prod_c = {8'd0, in_ta} * {8'd0, bosc_pkg::ALPHA_MAX - in_sa};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			src_s1  <= in_src;
			tgt_s1  <= in_tgt;
			sa_s1   <= in_sa;
			last_s1 <= in_last;
			prod_s1 <= prod_c;
		end
	end

	// stage 2: exact floor(p/255) for p up to 255*255, then output alpha
	assign div_sum = {1'b0, prod_s1} + {9'd0, prod_s1[15:8]} + 17'd1;
	assign cov_c   = div_sum[15:8];
	assign oa_c    = {1'b0, sa_s1} + {1'b0, cov_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			st_s2.src  <= src_s1;
			st_s2.tgt  <= tgt_s1;
			st_s2.last <= last_s1;
			st_s2.cov  <= cov_c;
			st_s2.oa   <= oa_c[7:0];
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = st_s2;

	// reciprocal divide matches true floor division
	a_cov_exact: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, cov_c} * 17'd255 <= {1'b0, prod_s1}) &&
		({1'b0, prod_s1} - {1'b0, cov_c} * 17'd255 < 17'd255))
		else $error("coverage quotient off");

	// output alpha cannot wrap
	a_oa_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !oa_c[8])
		else $error("output alpha overflow");

endmodule

// ===== rtl/bosc_div.sv =====
`timescale 1ns / 1ps

// Stages 3-5: restoring divider for w = cov*256/oa, three quotient bits a stage.
module bosc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bosc_pkg::alpha_st_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bosc_pkg::div_st_t   out_data
);

	logic              valid_s3;
	logic              valid_s4;
	logic              valid_s5;
	bosc_pkg::div_st_t st_s3;
	bosc_pkg::div_st_t st_s4;
	bosc_pkg::div_st_t st_s5;

	logic              adv_s3;
	logic              adv_s4;
	logic              adv_s5;
	bosc_pkg::div_st_t init_c;

	// shift-compare-subtract; the first step of the word takes no shift
	function automatic bosc_pkg::div_st_t div_steps(bosc_pkg::div_st_t st, logic first);
		bosc_pkg::div_st_t nx;
		logic [8:0]        r;
		logic [8:0]        d;
		logic              qb;
		nx = st;
		d  = {1'b0, st.oa};
		r  = st.rem;
		for (int i = 0; i < bosc_pkg::DIV_BITS_PER_STAGE; i++) begin
			if (!(first && (i == 0)))
				r = {r[7:0], 1'b0};
			qb     = (r >= d);
			nx.quo = {nx.quo[7:0], qb};
			if (qb)
				r = r - d;
		end
		nx.rem = r;
		return nx;
	endfunction

	assign adv_s5   = !valid_s5 || out_ready;
	assign adv_s4   = !valid_s4 || adv_s5;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign in_ready = adv_s3;

	// partial remainder starts at cov, which never exceeds oa
	always_comb begin
		init_c.src  = in_data.src;
		init_c.tgt  = in_data.tgt;
		init_c.last = in_data.last;
		init_c.oa   = in_data.oa;
		init_c.rem  = {1'b0, in_data.cov};
		init_c.quo  = '0;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s3) valid_s3 <= in_valid;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
		end
	end

	// quotient bits 8..6, 5..3, 2..0
	always_ff @(posedge clk) begin
		if (adv_s3 && in_valid) st_s3 <= div_steps(init_c, 1'b1);
		if (adv_s4 && valid_s3) st_s4 <= div_steps(st_s3, 1'b0);
		if (adv_s5 && valid_s4) st_s5 <= div_steps(st_s4, 1'b0);
	end

	assign out_valid = valid_s5;
	assign out_data  = st_s5;

	// weight stays within 0..256
	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && (st_s5.oa != 8'd0)) |-> (st_s5.quo <= bosc_pkg::WEIGHT_ONE))
		else $error("blend weight out of range");

	// final remainder is below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && (st_s5.oa != 8'd0)) |-> (st_s5.rem < {1'b0, st_s5.oa}))
		else $error("divider remainder not reduced");

endmodule

// ===== rtl/bosc_blend.sv =====
`timescale 1ns / 1ps

// Stage 6: per-channel weighted mix and zero-alpha clear, output register.
module bosc_blend (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bosc_pkg::div_st_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output bosc_pkg::pixel_t  out_data
);

	logic             valid_s6;
	bosc_pkg::pixel_t px_s6;
	bosc_pkg::pixel_t px_c;
	logic [8:0]       w;
	logic [8:0]       w_inv;

	// ((256-w)*s + w*t) >> 8, sum stays below 65536
	function automatic logic [7:0] mix(logic [8:0] wi, logic [8:0] wt,
		logic [7:0] s, logic [7:0] t);
		logic [16:0] acc;
		acc = {8'd0, wi} * {9'd0, s} + {8'd0, wt} * {9'd0, t};
		return acc[15:8];
	endfunction

	assign w     = in_data.quo;
	assign w_inv = bosc_pkg::WEIGHT_ONE - w;

	always_comb begin
		px_c.last = in_data.last;
		if (in_data.oa == 8'd0) begin
			px_c.col   = '0;
			px_c.alpha = '0;
		end else begin
			px_c.col.blue  = mix(w_inv, w, in_data.src.blue,  in_data.tgt.blue);
			px_c.col.green = mix(w_inv, w, in_data.src.green, in_data.tgt.green);
			px_c.col.red   = mix(w_inv, w, in_data.src.red,   in_data.tgt.red);
			px_c.alpha     = in_data.oa;
		end
	end

	assign in_ready = !valid_s6 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (in_ready) begin
			valid_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			px_s6 <= px_c;
	end

	assign out_valid = valid_s6;
	assign out_data  = px_s6;

	// transparent result carries no color
	a_zero_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s6 && (px_s6.alpha == 8'd0)) |-> (px_s6.col == '0))
		else $error("color left on transparent pixel");

endmodule
